// ===== hdl/bmt_pkg.sv =====
package bmt_pkg;

	// operation codes carried by the mode field
	typedef enum logic [2:0] {
		MODE_ADD    = 3'd0,
		MODE_REMOVE = 3'd1,
		MODE_ENABLE = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_MATCH  = 3'd4,
		MODE_LOOKUP = 3'd5
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SWEEP  = 2'd1,
		ST_COMMIT = 2'd2
	} state_t;

	localparam logic [2:0] KIND_EXECUTE = 3'd0;
	localparam logic [2:0] KIND_LIMIT   = 3'd5;
	localparam int         KINDS        = 5;

	// one breakpoint entry
	typedef struct packed {
		logic [15:0] id;
		logic [2:0]  kind;
		logic [15:0] address;
		logic [7:0]  value;
		logic        filter_on;
		logic        enabled;
		logic [31:0] hits;
	} entry_t;

	// operation token walking down the row of cells
	typedef struct packed {
		mode_t            mode;
		logic [2:0]       kind;
		logic [15:0]      address;
		logic [7:0]       data;
		logic [15:0]      id;
		logic             en;
		logic             found;
		entry_t           rep;
		logic [KINDS-1:0] mask;
	} token_t;

	// commit command broadcast to every cell
	typedef struct packed {
		logic   add_go;
		logic   shift_go;
		entry_t add_ent;
	} cmd_t;

endpackage

// ===== hdl/bmt_cell.sv =====
module bmt_cell #(
	parameter int SLOTS = 16,
	parameter int IDX   = 0,
	localparam int CW   = $clog2(SLOTS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [CW-1:0]   count,
	input  logic            in_valid,
	input  bmt_pkg::token_t in_tok,
	output logic            out_valid,
	output bmt_pkg::token_t out_tok,
	input  bmt_pkg::cmd_t   cmd,
	input  bmt_pkg::entry_t next_ent,
	output bmt_pkg::entry_t ent
);

	localparam logic [CW-1:0] MY = CW'(IDX);

	bmt_pkg::entry_t ent_q;
	bmt_pkg::entry_t upd;
	bmt_pkg::token_t tok_q;
	bmt_pkg::token_t nxt_tok;
	logic            out_valid_q;
	logic            shift_q;
	logic            live;
	logic            filt_ok;
	logic            claim;
	logic            gone;

	assign ent       = ent_q;
	assign out_tok   = tok_q;
	assign out_valid = out_valid_q;

	// local compare against the passing token
	always_comb begin
		live    = MY < count;
		filt_ok = !ent_q.filter_on || in_tok.kind == bmt_pkg::KIND_EXECUTE ||
			ent_q.value == in_tok.data;
		case (in_tok.mode)
			bmt_pkg::MODE_REMOVE, bmt_pkg::MODE_ENABLE, bmt_pkg::MODE_LOOKUP: begin
				claim = live && !in_tok.found && ent_q.id == in_tok.id;
			end
			bmt_pkg::MODE_MATCH: begin
				claim = live && !in_tok.found && ent_q.enabled &&
					in_tok.kind < bmt_pkg::KIND_LIMIT && ent_q.kind == in_tok.kind &&
					ent_q.address == in_tok.address && filt_ok;
			end
			default: begin
				claim = 1'b0;
			end
		endcase

		upd = ent_q;
		if (claim && in_tok.mode == bmt_pkg::MODE_ENABLE) begin
			upd.enabled = in_tok.en;
		end
		if (claim && in_tok.mode == bmt_pkg::MODE_MATCH && ent_q.hits != '1) begin
			upd.hits = ent_q.hits + 32'd1;
		end
		gone = claim && in_tok.mode == bmt_pkg::MODE_REMOVE;

		nxt_tok = in_tok;
		if (claim) begin
			nxt_tok.found = 1'b1;
			nxt_tok.rep   = upd;
		end
		// armed kinds as they stand after the operation
		if (live && upd.enabled && !gone && upd.kind < bmt_pkg::KIND_LIMIT) begin
			nxt_tok.mask = in_tok.mask | (bmt_pkg::KINDS'(1) << upd.kind);
		end
	end

	// token handoff to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			shift_q     <= 1'b0;
		end else begin
			out_valid_q <= in_valid;
			if (cmd.shift_go) begin
				shift_q <= 1'b0;
			end else if (in_valid && in_tok.mode == bmt_pkg::MODE_REMOVE &&
				(in_tok.found || claim)) begin
				shift_q <= 1'b1;
			end
		end
	end

	// entry storage and token payload
	always_ff @(posedge clk) begin
		tok_q <= nxt_tok;
		if (cmd.add_go && MY == count) begin
			ent_q <= cmd.add_ent;
		end else if (cmd.shift_go && shift_q) begin
			ent_q <= next_ent;
		end else if (in_valid) begin
			ent_q <= upd;
		end
	end

endmodule

// ===== hdl/breakpoint_match_table.sv =====
// Breakpoint match table.
// Input channel item_valid/item_ready carries one operation per item (add,
// remove, set enable, clear all, match access, lookup by id); the result
// channel result_valid/result_ready returns exactly one result per item.
// An item enters a row of SLOTS cells, one cell per entry in insertion
// order. The operation token moves one cell per cycle, so the first cell
// that claims it is the first entry in order; the token also collects the
// mask of armed kinds. After the last cell the commit state writes the result
// register and applies add (write at the fill position), remove (entries
// behind the removed one take their right neighbor's contents) or clear.
// From acceptance the token passes the launch register and the cell row
// before the commit state sets result_valid. A new item is taken once the
// previous one has committed, so only one item is ever in the cell row.
// item_ready is high whenever no item is in flight, even while a result
// waits: a stalled receiver only holds the commit of the next item.
// Reset empties the table and restarts ids at one; entry contents are not
// cleared, entries beyond the fill count are never read.
module breakpoint_match_table #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  mode,
	input  logic [2:0]  access_kind,
	input  logic [15:0] access_address,
	input  logic [7:0]  data_value,
	input  logic        filter_on,
	input  logic [15:0] entry_id,
	input  logic        enable_flag,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [15:0] found_id,
	output logic [2:0]  found_kind,
	output logic [15:0] found_address,
	output logic [7:0]  found_value,
	output logic        found_filter_on,
	output logic        found_enabled,
	output logic [31:0] hit_total,
	output logic [4:0]  armed_mask
);

	localparam int CW = $clog2(SLOTS + 1);

	bmt_pkg::state_t state_q, state_nxt;
	logic [CW-1:0]   count_q;
	logic [15:0]     next_number_q;
	bmt_pkg::token_t tok_s0;
	logic            tok_valid_s0;
	bmt_pkg::token_t end_q;
	bmt_pkg::token_t tok [SLOTS+1];
	logic            tv  [SLOTS+1];
	bmt_pkg::entry_t ent [SLOTS];
	bmt_pkg::cmd_t   cmd;
	logic            accept;
	logic            out_free;
	logic            commit_go;
	bmt_pkg::status_t res_status;
	bmt_pkg::entry_t res_rep;
	bmt_pkg::entry_t new_ent_q;
	logic [4:0]      res_mask;
	logic            do_add;
	logic            do_clear;
	logic            do_remove;

	logic             out_valid_q;
	bmt_pkg::status_t status_q;
	bmt_pkg::entry_t  rep_q;
	logic [4:0]       mask_q;

	assign accept    = item_valid && item_ready;
	assign out_free  = !out_valid_q || result_ready;
	assign commit_go = state_q == bmt_pkg::ST_COMMIT && out_free;

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		item_ready = 1'b0;
		case (state_q)
			bmt_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_nxt = bmt_pkg::ST_SWEEP;
				end
			end
			bmt_pkg::ST_SWEEP: begin
				if (tv[SLOTS]) begin
					state_nxt = bmt_pkg::ST_COMMIT;
				end
			end
			bmt_pkg::ST_COMMIT: begin
				if (out_free) begin
					state_nxt = bmt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bmt_pkg::ST_IDLE;
			end
		endcase
	end

	// token launch into the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s0 <= 1'b0;
		end else begin
			tok_valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s0.mode    <= bmt_pkg::mode_t'(mode);
			tok_s0.kind    <= access_kind;
			tok_s0.address <= access_address;
			tok_s0.data    <= data_value;
			tok_s0.id      <= entry_id;
			tok_s0.en      <= enable_flag;
			tok_s0.found   <= 1'b0;
			tok_s0.rep     <= '0;
			tok_s0.mask    <= '0;
			new_ent_q.id        <= next_number_q;
			new_ent_q.kind      <= access_kind;
			new_ent_q.address   <= access_address;
			new_ent_q.value     <= filter_on ? data_value : 8'd0;
			new_ent_q.filter_on <= filter_on;
			new_ent_q.enabled   <= 1'b1;
			new_ent_q.hits      <= 32'd0;
		end
		if (tv[SLOTS]) begin
			end_q <= tok[SLOTS];
		end
	end

	assign tok[0] = tok_s0;
	assign tv[0]  = tok_valid_s0;

	// row of entry cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		bmt_pkg::entry_t nb;
		if (i == SLOTS - 1) begin : g_last
			assign nb = ent[i];
		end else begin : g_mid
			assign nb = ent[i+1];
		end
		bmt_cell #(
			.SLOTS(SLOTS),
			.IDX  (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count    (count_q),
			.in_valid (tv[i]),
			.in_tok   (tok[i]),
			.out_valid(tv[i+1]),
			.out_tok  (tok[i+1]),
			.cmd      (cmd),
			.next_ent (nb),
			.ent      (ent[i])
		);
	end

	// result and table update from the finished token
	always_comb begin
		res_status = bmt_pkg::STAT_MISS;
		res_rep    = '0;
		res_mask   = end_q.mask;
		do_add     = 1'b0;
		do_clear   = 1'b0;
		do_remove  = 1'b0;
		case (end_q.mode)
			bmt_pkg::MODE_ADD: begin
				if (count_q >= CW'(SLOTS)) begin
					res_status = bmt_pkg::STAT_FULL;
				end else if (end_q.kind < bmt_pkg::KIND_LIMIT) begin
					res_status = bmt_pkg::STAT_OK;
					res_rep    = new_ent_q;
					res_mask   = end_q.mask | (5'(1) << end_q.kind);
					do_add     = 1'b1;
				end
			end
			bmt_pkg::MODE_REMOVE: begin
				if (end_q.found) begin
					res_status = bmt_pkg::STAT_OK;
					res_rep    = end_q.rep;
					do_remove  = 1'b1;
				end
			end
			bmt_pkg::MODE_ENABLE, bmt_pkg::MODE_MATCH, bmt_pkg::MODE_LOOKUP: begin
				if (end_q.found) begin
					res_status = bmt_pkg::STAT_OK;
					res_rep    = end_q.rep;
				end
			end
			bmt_pkg::MODE_CLEAR: begin
				res_status = bmt_pkg::STAT_OK;
				res_mask   = '0;
				do_clear   = 1'b1;
			end
			default: begin
				res_status = bmt_pkg::STAT_MISS;
			end
		endcase
		cmd.add_go   = commit_go && do_add;
		cmd.shift_go = commit_go;
		cmd.add_ent  = new_ent_q;
	end

	// fill count and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			next_number_q <= 16'd1;
		end else if (commit_go) begin
			if (do_add) begin
				count_q       <= count_q + CW'(1);
				next_number_q <= next_number_q + 16'd1;
			end else if (do_remove) begin
				count_q <= count_q - CW'(1);
			end else if (do_clear) begin
				count_q <= '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_go) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			status_q <= res_status;
			rep_q    <= res_rep;
			mask_q   <= res_mask;
		end
	end

	assign result_valid    = out_valid_q;
	assign status          = status_q;
	assign found_id        = rep_q.id;
	assign found_kind      = rep_q.kind;
	assign found_address   = rep_q.address;
	assign found_value     = rep_q.value;
	assign found_filter_on = rep_q.filter_on;
	assign found_enabled   = rep_q.enabled;
	assign hit_total       = rep_q.hits;
	assign armed_mask      = mask_q;

endmodule

// ===== hdl/bmt_checker.sv =====
module bmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  status,
	input logic [15:0] found_id,
	input logic [7:0]  found_value,
	input logic        found_filter_on,
	input logic        found_enabled,
	input logic [31:0] hit_total
);

	// a result waiting for the receiver stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is in flight");

	// no status code beyond table full
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= bmt_pkg::STAT_FULL)
		else $error("illegal status code");

	// a failed operation reports no entry
	a_miss_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != bmt_pkg::STAT_OK |->
		found_id == 16'd0 && hit_total == 32'd0 && !found_enabled)
		else $error("entry fields on a failed operation");

	// an entry without filter holds a zero filter byte
	a_filter_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found_filter_on |-> found_value == 8'd0)
		else $error("filter byte set without filter");

endmodule

bind breakpoint_match_table bmt_checker u_bmt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.status         (status),
	.found_id       (found_id),
	.found_value    (found_value),
	.found_filter_on(found_filter_on),
	.found_enabled  (found_enabled),
	.hit_total      (hit_total)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int SLOTS = 16;

	// access kinds beyond execute, and the out-of-range codes
	localparam logic [2:0] KIND_MEM_RD = 3'd1;
	localparam logic [2:0] KIND_MEM_WR = 3'd2;
	localparam logic [2:0] KIND_IO_RD  = 3'd3;
	localparam logic [2:0] KIND_IO_WR  = 3'd4;
	localparam logic [2:0] KIND_TOP    = 3'd7;
	localparam logic [2:0] MODE_BAD_A  = 3'd6;
	localparam logic [2:0] MODE_BAD_B  = 3'd7;

	localparam int HOLD_AT     = 250;
	localparam int HOLD_CYCLES = 300;

	// one operation as offered on the input channel
	typedef struct {
		logic [2:0]  mode;
		logic [2:0]  kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        filt;
		logic [15:0] id;
		logic        en;
		int          phase;
		bit          drain;
	} op_t;

	// one result as returned on the output channel
	typedef struct packed {
		bmt_pkg::status_t status;
		bmt_pkg::entry_t  ent;
		logic [4:0]       mask;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [2:0]  mode = '0;
	logic [2:0]  access_kind = '0;
	logic [15:0] access_address = '0;
	logic [7:0]  data_value = '0;
	logic        filter_on = 1'b0;
	logic [15:0] entry_id = '0;
	logic        enable_flag = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] found_id;
	logic [2:0]  found_kind;
	logic [15:0] found_address;
	logic [7:0]  found_value;
	logic        found_filter_on;
	logic        found_enabled;
	logic [31:0] hit_total;
	logic [4:0]  armed_mask;

	// idle percentages per phase: none, sender, receiver, both
	int send_idle_pct[4]  = '{0, 73, 0, 15};
	int recv_stall_pct[4] = '{0, 0, 73, 15};

	op_t     pending_ops[$];
	report_t awaited_reports[$];
	op_t     cur_op;
	int      cur_phase = 0;
	logic    rx_hold = 1'b0;

	// predicted breakpoint table
	bmt_pkg::entry_t tab[SLOTS];
	int              tab_count = 0;
	logic [15:0]     tab_next = 16'd1;

	// planning view of the table, used only to aim the stimulus
	bmt_pkg::entry_t plan_tab[$];
	logic [15:0]     gen_next = 16'd1;
	int              gen_phase = 0;
	bit              gen_drain = 1'b0;

	int n_accepted = 0;
	int n_checked = 0;
	int n_hits = 0;
	int n_full = 0;
	int n_fail = 0;

	logic [15:0] addr_pool[6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h1234, 16'hA5A5};
	logic [7:0]  byte_pool[4] = '{8'h00, 8'hFF, 8'hA5, 8'h5A};

	breakpoint_match_table #(.SLOTS(SLOTS)) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.mode            (mode),
		.access_kind     (access_kind),
		.access_address  (access_address),
		.data_value      (data_value),
		.filter_on       (filter_on),
		.entry_id        (entry_id),
		.enable_flag     (enable_flag),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.status          (status),
		.found_id        (found_id),
		.found_kind      (found_kind),
		.found_address   (found_address),
		.found_value     (found_value),
		.found_filter_on (found_filter_on),
		.found_enabled   (found_enabled),
		.hit_total       (hit_total),
		.armed_mask      (armed_mask)
	);

	// clock and reset
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// first position holding this id, or the fill count if none
	function automatic int find_entry(logic [15:0] id);
		int k;
		for (k = 0; k < tab_count; k++)
			if (tab[k].id == id)
				return k;
		return tab_count;
	endfunction

	// apply one operation to the predicted table and work out its result
	function automatic report_t table_apply(op_t op);
		report_t r;
		int      pos;
		int      k;
		r = '0;
		r.status = bmt_pkg::STAT_MISS;
		case (op.mode)
			bmt_pkg::MODE_ADD: begin
				if (tab_count >= SLOTS)
					r.status = bmt_pkg::STAT_FULL;
				else if (op.kind < bmt_pkg::KIND_LIMIT) begin
					tab[tab_count] = '{id: tab_next, kind: op.kind, address: op.addr,
						value: op.filt ? op.data : 8'd0, filter_on: op.filt,
						enabled: 1'b1, hits: 32'd0};
					r.ent = tab[tab_count];
					r.status = bmt_pkg::STAT_OK;
					tab_count++;
					tab_next = tab_next + 16'd1;
				end
			end
			bmt_pkg::MODE_REMOVE, bmt_pkg::MODE_ENABLE, bmt_pkg::MODE_LOOKUP: begin
				pos = find_entry(op.id);
				if (pos < tab_count) begin
					if (op.mode == bmt_pkg::MODE_ENABLE)
						tab[pos].enabled = op.en;
					r.ent = tab[pos];
					r.status = bmt_pkg::STAT_OK;
					// remove closes the gap, keeping insertion order
					if (op.mode == bmt_pkg::MODE_REMOVE) begin
						for (k = pos; k < tab_count - 1; k++)
							tab[k] = tab[k + 1];
						tab_count--;
					end
				end
			end
			bmt_pkg::MODE_CLEAR: begin
				tab_count = 0;
				r.status = bmt_pkg::STAT_OK;
			end
			bmt_pkg::MODE_MATCH: begin
				// first enabled entry in order; execute ignores the filter byte
				if (op.kind < bmt_pkg::KIND_LIMIT)
					for (k = 0; k < tab_count; k++) begin
						if (tab[k].enabled && tab[k].kind == op.kind &&
						    tab[k].address == op.addr &&
						    !(tab[k].filter_on && op.kind != bmt_pkg::KIND_EXECUTE &&
						      tab[k].value != op.data)) begin
							if (tab[k].hits != 32'hFFFF_FFFF)
								tab[k].hits = tab[k].hits + 32'd1;
							r.ent = tab[k];
							r.status = bmt_pkg::STAT_OK;
							break;
						end
					end
			end
			default: ;
		endcase
		// armed kinds after the operation
		for (k = 0; k < tab_count; k++)
			if (tab[k].enabled && tab[k].kind < bmt_pkg::KIND_LIMIT)
				r.mask[tab[k].kind] = 1'b1;
		return r;
	endfunction

	task automatic note_failure(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			note_failure($sformatf("result %0d field %s: expected %0h, got %0h",
				n_checked, name, want, got));
	endtask

	function automatic op_t make_op(logic [2:0] md, logic [2:0] kd, logic [15:0] ad,
		logic [7:0] dv, logic fo, logic [15:0] id, logic en);
		op_t o;
		o.mode = md;
		o.kind = kd;
		o.addr = ad;
		o.data = dv;
		o.filt = fo;
		o.id = id;
		o.en = en;
		o.phase = 0;
		o.drain = 1'b0;
		return o;
	endfunction

	// queue an item and keep the planning view in step with it
	task automatic queue_op(op_t o);
		int              k;
		bmt_pkg::entry_t ne;
		o.phase = gen_phase;
		o.drain = gen_drain;
		gen_drain = 1'b0;
		case (o.mode)
			bmt_pkg::MODE_ADD: begin
				if (plan_tab.size() < SLOTS && o.kind < bmt_pkg::KIND_LIMIT) begin
					ne = '{id: gen_next, kind: o.kind, address: o.addr,
						value: o.data, filter_on: o.filt, enabled: 1'b1, hits: 32'd0};
					plan_tab = {plan_tab, ne};
					gen_next = gen_next + 16'd1;
				end
			end
			bmt_pkg::MODE_REMOVE: begin
				for (k = 0; k < plan_tab.size(); k++)
					if (plan_tab[k].id == o.id) begin
						plan_tab.delete(k);
						break;
					end
			end
			bmt_pkg::MODE_CLEAR: plan_tab.delete();
			default: ;
		endcase
		pending_ops = {pending_ops, o};
	endtask

	function automatic logic [2:0] rand_kind();
		if ($urandom_range(19) == 0)
			return 3'($urandom_range(KIND_TOP, bmt_pkg::KIND_LIMIT));
		return 3'($urandom_range(KIND_IO_WR, bmt_pkg::KIND_EXECUTE));
	endfunction

	function automatic logic [15:0] rand_addr();
		if ($urandom_range(6) == 0)
			return 16'($urandom);
		return addr_pool[$urandom_range(5)];
	endfunction

	function automatic logic [7:0] rand_byte();
		if ($urandom_range(4) == 0)
			return 8'($urandom);
		return byte_pool[$urandom_range(3)];
	endfunction

	// random operation, mostly aimed at entries that exist
	task automatic queue_random_op();
		op_t             o;
		bmt_pkg::entry_t pick;
		int              r;
		o = make_op(bmt_pkg::MODE_ADD, rand_kind(), rand_addr(), rand_byte(),
			1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)));
		pick = '0;
		if (plan_tab.size() > 0)
			pick = plan_tab[$urandom_range(plan_tab.size() - 1)];
		r = $urandom_range(99);
		if (r < 30)
			o.mode = bmt_pkg::MODE_ADD;
		else if (r < 62) begin
			o.mode = bmt_pkg::MODE_MATCH;
			if (plan_tab.size() > 0 && $urandom_range(9) < 7) begin
				o.kind = pick.kind;
				o.addr = pick.address;
				if ($urandom_range(4) != 0)
					o.data = pick.value;
			end
		end else if (r < 92) begin
			o.mode = (r < 72) ? bmt_pkg::MODE_REMOVE :
				(r < 82) ? bmt_pkg::MODE_ENABLE : bmt_pkg::MODE_LOOKUP;
			if (plan_tab.size() > 0 && $urandom_range(4) != 0)
				o.id = pick.id;
		end else if (r < 95)
			o.mode = bmt_pkg::MODE_CLEAR;
		else
			o.mode = $urandom_range(1) ? MODE_BAD_A : MODE_BAD_B;
		queue_op(o);
	endtask

	// driver: presents queued items, predicts each one as it is accepted
	always @(posedge clk or negedge arst_n) begin : driver
		report_t want;
		bit      free;
		op_t     nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			free = !item_valid;
			if (item_valid && item_ready) begin
				want = table_apply(cur_op);
				awaited_reports = {awaited_reports, want};
				n_accepted++;
				if (cur_op.mode == bmt_pkg::MODE_MATCH && want.status == bmt_pkg::STAT_OK)
					n_hits++;
				if (want.status == bmt_pkg::STAT_FULL)
					n_full++;
				free = 1'b1;
			end
			// a drain item waits until every result is back
			if (free) begin
				if (pending_ops.size() > 0 &&
				    !(pending_ops[0].drain && awaited_reports.size() > 0) &&
				    $urandom_range(99) >= send_idle_pct[pending_ops[0].phase]) begin
					nxt = pending_ops.pop_front();
					cur_op = nxt;
					item_valid <= 1'b1;
					mode <= nxt.mode;
					access_kind <= nxt.kind;
					access_address <= nxt.addr;
					data_value <= nxt.data;
					filter_on <= nxt.filt;
					entry_id <= nxt.id;
					enable_flag <= nxt.en;
					cur_phase <= nxt.phase;
				end else
					item_valid <= 1'b0;
			end
		end
	end

	// monitor: compares each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : monitor
		report_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (awaited_reports.size() == 0) begin
					note_failure($sformatf("result with no pending item: status %0d id %0h",
						status, found_id));
				end else begin
					want = awaited_reports.pop_front();
					n_checked++;
					check_field("status", want.status, status);
					check_field("found_id", want.ent.id, found_id);
					check_field("found_kind", want.ent.kind, found_kind);
					check_field("found_address", want.ent.address, found_address);
					check_field("found_value", want.ent.value, found_value);
					check_field("found_filter_on", want.ent.filter_on, found_filter_on);
					check_field("found_enabled", want.ent.enabled, found_enabled);
					check_field("hit_total", want.ent.hits, hit_total);
					check_field("armed_mask", want.mask, armed_mask);
				end
			end
			result_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct[cur_phase]);
		end
	end

	// long receiver hold-off while the sender keeps offering items
	initial begin : receiver_hold
		while (n_accepted < HOLD_AT)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// stimulus and end of run
	initial begin : stimulus
		int i;

		// directed: empty table, every kind, filters, enable, remove, bad codes
		queue_op(make_op(bmt_pkg::MODE_LOOKUP, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0001, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_MATCH, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_ADD, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'hFF,
			1'b1, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_ADD, KIND_MEM_RD, 16'hFFFF, 8'hA5,
			1'b1, 16'hFFFF, 1'b1));
		queue_op(make_op(bmt_pkg::MODE_ADD, KIND_MEM_WR, 16'h1234, 8'h5A,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_ADD, KIND_IO_RD, 16'h8000, 8'h00,
			1'b1, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_ADD, KIND_IO_WR, 16'h7FFF, 8'h3C,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_ADD, KIND_TOP, 16'h4444, 8'h11,
			1'b1, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_MATCH, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h12,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_MATCH, KIND_MEM_RD, 16'hFFFF, 8'hA4,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_MATCH, KIND_MEM_RD, 16'hFFFF, 8'hA5,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_MATCH, bmt_pkg::KIND_LIMIT, 16'hFFFF, 8'hA5,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_MATCH, KIND_MEM_WR, 16'h1234, 8'h77,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_ENABLE, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0002, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_MATCH, KIND_MEM_RD, 16'hFFFF, 8'hA5,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_ENABLE, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0002, 1'b1));
		queue_op(make_op(bmt_pkg::MODE_REMOVE, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0003, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_LOOKUP, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0004, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_LOOKUP, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0003, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_REMOVE, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_LOOKUP, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'hFFFF, 1'b0));
		queue_op(make_op(MODE_BAD_A, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0001, 1'b1));
		queue_op(make_op(MODE_BAD_B, KIND_TOP, 16'hFFFF, 8'hFF,
			1'b1, 16'hFFFF, 1'b1));
		queue_op(make_op(bmt_pkg::MODE_MATCH, KIND_IO_WR, 16'h7FFF, 8'h00,
			1'b0, 16'h0000, 1'b0));
		queue_op(make_op(bmt_pkg::MODE_CLEAR, bmt_pkg::KIND_EXECUTE, 16'h0000, 8'h00,
			1'b0, 16'h0000, 1'b0));

		// random operations, idle pattern changing every hundred items
		for (i = 0; i < 800; i++) begin
			if (i % 100 == 0) begin
				gen_phase = (i / 100) % 4;
				gen_drain = 1'b1;
			end
			queue_random_op();
		end

		// short tail with both sides idling
		gen_phase = 3;
		gen_drain = 1'b1;
		for (i = 0; i < 40; i++)
			queue_random_op();

		// wait for the last item, its result, and some quiet cycles
		while (pending_ops.size() > 0 || item_valid)
			@(posedge clk);
		while (awaited_reports.size() > 0)
			@(posedge clk);
		repeat (4 * (SLOTS + 3)) @(posedge clk);
		if (awaited_reports.size() > 0)
			note_failure($sformatf("%0d results never arrived", awaited_reports.size()));

		$display("%0d operations checked, %0d access hits, %0d adds refused on a full table",
			n_checked, n_hits, n_full);
		$display("all six modes plus bad codes, under four idle patterns and a long stall");
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#1_000_000;
		$display("timeout: %0d items accepted, %0d results checked", n_accepted, n_checked);
		$display("Test completed with failures");
		$finish;
	end

endmodule
